FILE: design/wcc_pkg.sv
// Shared constants, codes and types of the wall crossing clamp.
package wcc_pkg;

  localparam int MAX_WALLS_DEF  = 64;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int T_BITS         = 17;
  localparam int STEP_BITS      = $clog2(T_BITS + 1);

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);

  // Action codes of an input item.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BAND,
    ST_MUL,
    ST_CHK,
    ST_DSTART,
    ST_DWAIT,
    ST_SCL_X,
    ST_SCL_Z,
    ST_UPD,
    ST_NEXT,
    ST_FIN
  } state_t;

  // Status of one ratio division.
  typedef struct packed {
    logic              done;
    logic              ok;
    logic [T_BITS-1:0] q;
  } div_res_t;

endpackage

FILE: design/wcc_if.sv
// Handshake channels for the items going into and out of the clamp unit.
interface wcc_in_if import wcc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [COORD_BITS-1:0] wall_start_x;
  logic [COORD_BITS-1:0] wall_start_z;
  logic [COORD_BITS-1:0] wall_end_x;
  logic [COORD_BITS-1:0] wall_end_z;
  logic [COORD_BITS-1:0] wall_bottom;
  logic [COORD_BITS-1:0] wall_top;
  logic [COORD_BITS-1:0] height;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_z;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_z;

  modport source (output valid, action, wall_start_x, wall_start_z, wall_end_x, wall_end_z,
                  wall_bottom, wall_top, height, prev_x, prev_z, new_x, new_z,
                  input ready);
  modport sink (input valid, action, wall_start_x, wall_start_z, wall_end_x, wall_end_z,
                wall_bottom, wall_top, height, prev_x, prev_z, new_x, new_z,
                output ready);
endinterface

interface wcc_out_if import wcc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_z;
  logic                  clamped;
  logic                  status;

  modport source (output valid, out_x, out_z, clamped, status, input ready);
  modport sink (input valid, out_x, out_z, clamped, status, output ready);
endinterface

FILE: design/wcc_wall_mem.sv
// Wall table memory: one write port, one registered read port.
module wcc_wall_mem import wcc_pkg::*; #(
  parameter int DEPTH = MAX_WALLS_DEF,
  parameter int WIDTH = 6 * COORD_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/wcc_div.sv
// Bit-serial Q1.16 ratio divider with range check for the crossing parameters.
module wcc_div import wcc_pkg::*; #(
  parameter int XW = 2 * (COORD_BITS_DEF + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [XW-1:0] num,
  input  logic [XW-1:0] den,
  output div_res_t      res
);

  logic [XW:0]            rem_r;
  logic [XW-1:0]          d_r;
  logic [T_BITS-1:0]      q_r;
  logic [STEP_BITS-1:0]   cnt_r;
  logic                   neg_r;
  logic                   ovf_r;
  logic                   busy_r;
  logic                   done_r;
  logic [XW-1:0]          n_mag;
  logic [XW-1:0]          d_mag;
  logic                   ge;
  logic [XW:0]            diff;

  // Magnitudes of the operands.
  assign n_mag = num[XW-1] ? (~num + XW'(1)) : num;
  assign d_mag = den[XW-1] ? (~den + XW'(1)) : den;

  // One quotient bit per cycle; the remainder stays below twice the divisor unless the ratio overflows.
  assign ge   = (rem_r >= {1'b0, d_r});
  assign diff = ge ? (rem_r - {1'b0, d_r}) : rem_r;

  // Control state of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == STEP_BITS'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, n_mag};
      d_r   <= d_mag;
      q_r   <= '0;
      cnt_r <= STEP_BITS'(T_BITS);
      neg_r <= num[XW-1] ^ den[XW-1];
      // A numerator of twice the divisor or more gives a ratio of two or more.
      ovf_r <= ({1'b0, n_mag} >= {d_mag, 1'b0});
    end else if (busy_r) begin
      rem_r <= {diff[XW-1:0], 1'b0};
      q_r   <= {q_r[T_BITS-2:0], ge};
      cnt_r <= cnt_r - STEP_BITS'(1);
    end
  end

  // The ratio is usable when it lies in [0, 1] after truncation toward zero.
  assign res.done = done_r;
  assign res.q    = q_r;
  assign res.ok   = done_r && !ovf_r && (q_r <= T_ONE) && !(neg_r && (q_r != '0));

endmodule

FILE: design/wall_crossing_clamp_unit.sv
// Wall crossing clamp: a query walks the wall table, one wall after another.
// A clear or append item goes from acceptance straight to the finish state and its result.
// A query walks each wall through read, band check, cross products and facing check,
// then the ratio divisions, and the scaling and update only when both ratios are in range.
// Throughput: one item at a time; the next item is accepted while a result waits.
// Reset empties the wall table count; stored walls are not cleared.
module wall_crossing_clamp_unit import wcc_pkg::*; #(
  parameter int MAX_WALLS  = MAX_WALLS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  wcc_in_if.sink      in_ch,
  wcc_out_if.source   out_ch
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int MW = CB + 2;
  localparam int XW = 2 * MW;
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int WW = 6 * CB;

  state_t state_r, state_nxt;

  logic [CW-1:0]        walls_r;
  logic [CW-1:0]        k_r;
  logic [2:0]           m_r;
  logic [CB-1:0]        h_r, px_r, pz_r, cx_r, cz_r, nx_r;
  logic                 clamped_r, status_r;
  logic [DW-1:0]        rx_r, rz_r, sx_r, sz_r, qx_r, qz_r;
  logic [XW-1:0]        prod_r, acc_r, c_r, tn_r, un_r;
  logic [T_BITS-1:0]    t_r;
  logic                 out_valid_r;
  logic [CB-1:0]        out_x_r, out_z_r;
  logic                 out_clamped_r, out_status_r;

  logic                 accept;
  logic                 in_ready;
  logic                 mem_wr_en, mem_rd_en, div_start;
  logic                 out_free;
  logic                 last_wall;
  logic [WW-1:0]        wr_data, rd_data;
  logic [CB-1:0]        w_sx, w_sz, w_ex, w_ez, w_bot, w_top;
  logic                 in_band;
  logic signed [MW-1:0] op_a, op_b;
  div_res_t             div_t_res, div_u_res;

  assign accept    = in_ch.valid && in_ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_wall = (k_r + CW'(1)) == walls_r;

  // Wall record layout in the table.
  assign wr_data = {in_ch.wall_start_x, in_ch.wall_start_z, in_ch.wall_end_x,
                    in_ch.wall_end_z, in_ch.wall_bottom, in_ch.wall_top};
  assign w_sx  = rd_data[6*CB-1:5*CB];
  assign w_sz  = rd_data[5*CB-1:4*CB];
  assign w_ex  = rd_data[4*CB-1:3*CB];
  assign w_ez  = rd_data[3*CB-1:2*CB];
  assign w_bot = rd_data[2*CB-1:CB];
  assign w_top = rd_data[CB-1:0];

  assign in_band = !($signed(h_r) < $signed(w_bot)) && !($signed(h_r) > $signed(w_top));

  wcc_wall_mem #(
    .DEPTH (MAX_WALLS),
    .WIDTH (WW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (walls_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (rd_data)
  );

  wcc_div #(.XW(XW)) u_div_t (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tn_r),
    .den   (c_r),
    .res   (div_t_res)
  );

  wcc_div #(.XW(XW)) u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (un_r),
    .den   (c_r),
    .res   (div_u_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == ACT_QUERY && walls_r != '0) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_READ:   state_nxt = ST_BAND;
      ST_BAND:   state_nxt = in_band ? ST_MUL : ST_NEXT;
      ST_MUL:    state_nxt = (m_r == 3'd6) ? ST_CHK : ST_MUL;
      ST_CHK:    state_nxt = c_r[XW-1] ? ST_DSTART : ST_NEXT;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_t_res.done) begin
          state_nxt = (div_t_res.ok && div_u_res.ok) ? ST_SCL_X : ST_NEXT;
        end
      end
      ST_SCL_X:  state_nxt = ST_SCL_Z;
      ST_SCL_Z:  state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = last_wall ? ST_FIN : ST_READ;
      ST_FIN:    state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_wr_en = accept && in_ch.action == ACT_APPEND && walls_r != CW'(MAX_WALLS);
      end
      ST_READ:   mem_rd_en = 1'b1;
      ST_DSTART: div_start = 1'b1;
      default:   in_ready  = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walls_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_ch.action == ACT_CLEAR) begin
        walls_r <= '0;
      end else if (mem_wr_en) begin
        walls_r <= walls_r + CW'(1);
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_MUL: begin
        case (m_r)
          3'd0: begin op_a = MW'($signed(rx_r)); op_b = MW'($signed(sz_r)); end
          3'd1: begin op_a = MW'($signed(rz_r)); op_b = MW'($signed(sx_r)); end
          3'd2: begin op_a = MW'($signed(qx_r)); op_b = MW'($signed(sz_r)); end
          3'd3: begin op_a = MW'($signed(qz_r)); op_b = MW'($signed(sx_r)); end
          3'd4: begin op_a = MW'($signed(qx_r)); op_b = MW'($signed(rz_r)); end
          3'd5: begin op_a = MW'($signed(qz_r)); op_b = MW'($signed(rx_r)); end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      ST_SCL_X: begin
        op_a = $signed({{(MW-T_BITS){1'b0}}, t_r});
        op_b = MW'($signed(rx_r));
      end
      ST_SCL_Z: begin
        op_a = $signed({{(MW-T_BITS){1'b0}}, t_r});
        op_b = MW'($signed(rz_r));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Product register after the multiplier.
  always_ff @(posedge clk) begin
    prod_r <= XW'(op_a * op_b);
  end

  // Query datapath: per-wall differences, cross products and position update.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_r       <= '0;
          h_r       <= in_ch.height;
          px_r      <= in_ch.prev_x;
          pz_r      <= in_ch.prev_z;
          clamped_r <= 1'b0;
          status_r  <= in_ch.action == ACT_APPEND && walls_r == CW'(MAX_WALLS);
          if (in_ch.action == ACT_QUERY) begin
            cx_r <= in_ch.new_x;
            cz_r <= in_ch.new_z;
          end else begin
            cx_r <= '0;
            cz_r <= '0;
          end
        end
      end
      ST_BAND: begin
        m_r  <= '0;
        rx_r <= {w_ex[CB-1], w_ex} - {w_sx[CB-1], w_sx};
        rz_r <= {w_ez[CB-1], w_ez} - {w_sz[CB-1], w_sz};
        sx_r <= {cx_r[CB-1], cx_r} - {px_r[CB-1], px_r};
        sz_r <= {cz_r[CB-1], cz_r} - {pz_r[CB-1], pz_r};
        qx_r <= {px_r[CB-1], px_r} - {w_sx[CB-1], w_sx};
        qz_r <= {pz_r[CB-1], pz_r} - {w_sz[CB-1], w_sz};
      end
      ST_MUL: begin
        m_r <= m_r + 3'd1;
        // Each cross product is the first product minus the second.
        case (m_r)
          3'd1, 3'd3, 3'd5: acc_r <= prod_r;
          3'd2: c_r  <= acc_r - prod_r;
          3'd4: tn_r <= acc_r - prod_r;
          3'd6: un_r <= acc_r - prod_r;
          default: acc_r <= acc_r;
        endcase
      end
      ST_DWAIT: t_r <= div_t_res.q;
      ST_SCL_Z: nx_r <= w_sx + prod_r[CB+FRAC_BITS-1:FRAC_BITS];
      ST_UPD: begin
        cx_r      <= nx_r;
        cz_r      <= w_sz + prod_r[CB+FRAC_BITS-1:FRAC_BITS];
        clamped_r <= 1'b1;
      end
      ST_NEXT: k_r <= k_r + CW'(1);
      default: k_r <= k_r;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_x_r       <= cx_r;
      out_z_r       <= cz_r;
      out_clamped_r <= clamped_r;
      out_status_r  <= status_r;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_x   = out_x_r;
  assign out_ch.out_z   = out_z_r;
  assign out_ch.clamped = out_clamped_r;
  assign out_ch.status  = out_status_r;

  // The wall count never passes the table size.
  a_walls_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walls_r <= CW'(MAX_WALLS))
    else $error("wall count beyond table size");

  // A wall read always lies within the filled part of the table.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> k_r < walls_r)
    else $error("read of a wall beyond the count");

  // Both ratio dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_t_res.done == div_u_res.done)
    else $error("ratio dividers out of step");

  // A position update marks the query as clamped.
  a_update_marks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> clamped_r)
    else $error("position update without clamp flag");

  // A finished item reaches the output register when the slot is empty.
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && !out_valid_r |=> out_valid_r)
    else $error("finished item not presented");

endmodule

FILE: test/tb.sv
// Testbench of the wall crossing clamp unit: directed table, a full table, then random scenes.
`timescale 1ns / 1ps
module tb;
  import wcc_pkg::*;

  localparam int NWALL = MAX_WALLS_DEF;
  localparam longint TIMEOUT_CYCLES = 4000000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] wsx, wsz, wex, wez, wbot, wtop;
    logic [31:0] h, px, pz, nx, nz;
  } move_item_t;

  typedef struct {
    logic [31:0] x, z;
    logic        clamped, status;
  } clamp_result_t;

  typedef struct {
    move_item_t    item;
    bit            typed;
    clamp_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycle_count = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int queries_sent = 0;
  bit idle_phase = 1'b0;
  bit stim_done = 1'b0;

  wcc_in_if  in_ch ();
  wcc_out_if out_ch ();

  wall_crossing_clamp_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Local copy of the wall table.
  longint wall_sx[NWALL], wall_sz[NWALL], wall_ex[NWALL], wall_ez[NWALL];
  longint wall_bot[NWALL], wall_top[NWALL];
  int tb_walls = 0;

  clamp_result_t expected_results[$];

  // Ratio num*2^16/den truncated toward zero; fails unless within [0, 1].
  function automatic bit ratio_in_unit(logic signed [127:0] num, logic signed [127:0] den,
                                       output logic [16:0] q);
    logic [127:0] n, d, quo;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    quo = (n << 16) / d;
    q = quo[16:0];
    if (quo > 128'd65536) return 1'b0;
    if (neg && quo != 0) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one item to the local table and works out its result.
  function automatic clamp_result_t predict_clamp(move_item_t it);
    clamp_result_t r;
    longint h, px, pz, cx, cz, rx, rz, sx, sz, qx, qz;
    logic signed [127:0] c, tn, un, p;
    logic [16:0] t, u;
    r = '{32'd0, 32'd0, 1'b0, 1'b0};
    if (it.action == ACT_CLEAR) begin
      tb_walls = 0;
    end else if (it.action == ACT_APPEND) begin
      if (tb_walls >= NWALL) begin
        r.status = 1'b1;
      end else begin
        wall_sx[tb_walls] = $signed(it.wsx);
        wall_sz[tb_walls] = $signed(it.wsz);
        wall_ex[tb_walls] = $signed(it.wex);
        wall_ez[tb_walls] = $signed(it.wez);
        wall_bot[tb_walls] = $signed(it.wbot);
        wall_top[tb_walls] = $signed(it.wtop);
        tb_walls++;
      end
    end else if (it.action == ACT_QUERY) begin
      h = $signed(it.h);
      px = $signed(it.px);
      pz = $signed(it.pz);
      cx = $signed(it.nx);
      cz = $signed(it.nz);
      for (int k = 0; k < tb_walls; k++) begin
        if (h < wall_bot[k] || h > wall_top[k]) continue;
        rx = wall_ex[k] - wall_sx[k];
        rz = wall_ez[k] - wall_sz[k];
        sx = cx - px;
        sz = cz - pz;
        c = 128'(rx) * 128'(sz) - 128'(rz) * 128'(sx);
        if (c >= 0) continue;
        qx = px - wall_sx[k];
        qz = pz - wall_sz[k];
        tn = 128'(qx) * 128'(sz) - 128'(qz) * 128'(sx);
        un = 128'(qx) * 128'(rz) - 128'(qz) * 128'(rx);
        if (!ratio_in_unit(tn, c, t)) continue;
        if (!ratio_in_unit(un, c, u)) continue;
        p = 128'(longint'(t)) * 128'(rx);
        cx = wall_sx[k] + longint'(p >>> 16);
        p = 128'(longint'(t)) * 128'(rz);
        cz = wall_sz[k] + longint'(p >>> 16);
        r.clamped = 1'b1;
      end
      r.x = cx[31:0];
      r.z = cz[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Result side: random stalls, compare with the oldest expectation.
  initial begin
    int stall;
    clamp_result_t e;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!idle_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 3);
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", out_ch.out_x, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.out_x !== e.x) report_mismatch("out_x", out_ch.out_x, e.x);
          if (out_ch.out_z !== e.z) report_mismatch("out_z", out_ch.out_z, e.z);
          if (out_ch.clamped !== e.clamped)
            report_mismatch("clamped", out_ch.clamped, e.clamped);
          if (out_ch.status !== e.status)
            report_mismatch("status", out_ch.status, e.status);
        end
        results_seen++;
      end
    end
  end

  // Sends one item, with an optional idle burst first, and records its expectation.
  task automatic send_item(move_item_t it, bit typed, clamp_result_t want);
    clamp_result_t pred;
    if (!idle_phase && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action;
    in_ch.wall_start_x <= it.wsx;
    in_ch.wall_start_z <= it.wsz;
    in_ch.wall_end_x <= it.wex;
    in_ch.wall_end_z <= it.wez;
    in_ch.wall_bottom <= it.wbot;
    in_ch.wall_top <= it.wtop;
    in_ch.height <= it.h;
    in_ch.prev_x <= it.px;
    in_ch.prev_z <= it.pz;
    in_ch.new_x <= it.nx;
    in_ch.new_z <= it.nz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = predict_clamp(it);
    if (it.action == ACT_QUERY) queries_sent++;
    expected_results.insert(expected_results.size(), typed ? want : pred);
    if (typed && (pred.x !== want.x || pred.z !== want.z ||
                  pred.clamped !== want.clamped || pred.status !== want.status)) begin
      report_mismatch("table row against predictor", pred.x, want.x);
    end
  endtask

  function automatic move_item_t mk(logic [1:0] a, logic [31:0] sx, sz, ex, ez, bt, tp,
                                    logic [31:0] h, px, pz, nx, nz);
    move_item_t it;
    it = '{a, sx, sz, ex, ez, bt, tp, h, px, pz, nx, nz};
    return it;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // Mostly small coordinates, sometimes full range.
  function automatic logic [31:0] rcoord();
    int v;
    if ($urandom_range(0, 9) == 0) return $urandom();
    v = $urandom_range(0, 40 * 65536) - 20 * 65536;
    return v;
  endfunction

  function automatic move_item_t rand_wall();
    logic [31:0] b;
    b = $urandom_range(0, 7) == 0 ? rnd32() : -32'sd65536 * $urandom_range(0, 4);
    return mk(ACT_APPEND, rcoord(), rcoord(), rcoord(), rcoord(), b,
              $urandom_range(0, 7) == 0 ? rnd32() : 32'(65536 * $urandom_range(0, 4)),
              0, 0, 0, 0, 0);
  endfunction

  function automatic move_item_t rand_query();
    return mk(ACT_QUERY, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
              $urandom_range(0, 7) == 0 ? rnd32() : 32'(65536 * $urandom_range(0, 3)),
              rcoord(), rcoord(), rcoord(), rcoord());
  endfunction

  // Stimulus.
  initial begin
    table_row_t rows[$];
    clamp_result_t zero_res, full_res;
    move_item_t it;
    int n;
    zero_res = '{32'd0, 32'd0, 1'b0, 1'b0};
    full_res = '{32'd0, 32'd0, 1'b0, 1'b1};
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_CLEAR;
    {in_ch.wall_start_x, in_ch.wall_start_z, in_ch.wall_end_x, in_ch.wall_end_z} <= '0;
    {in_ch.wall_bottom, in_ch.wall_top, in_ch.height} <= '0;
    {in_ch.prev_x, in_ch.prev_z, in_ch.new_x, in_ch.new_z} <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Query on an empty table passes the new position through.
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff,
                                  32'h80000000),
                               1, '{32'h7fffffff, 32'h80000000, 1'b0, 1'b0}});
    rows.insert(rows.size(), '{mk(ACT_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
                               1, zero_res});
    // Wall along z at x=0, band [-1,1]; moving +x crosses it.
    rows.insert(rows.size(), '{mk(ACT_APPEND, 0, 32'hfffb0000, 0, 32'h00050000, 32'hffff0000,
                                  32'h00010000, 0, 0, 0, 0, 0), 1, zero_res});
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'hfffe0000, 0,
                                  32'h00020000, 0), 0, zero_res});
    // Opposite direction runs against the facing.
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h00020000, 0,
                                  32'hfffe0000, 0), 0, zero_res});
    // Out of band, and parallel motion.
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h00020000, 32'hfffe0000, 0,
                                  32'h00020000, 0), 0, zero_res});
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h00010000, 0,
                                  32'h00010000, 32'h00030000), 0, zero_res});
    // Touching endpoint exactly, and a move that ends on the wall.
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'hffff0000, 32'h00050000,
                                  0, 32'h00050000), 0, zero_res});
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff0000, 32'hfffe0000, 0,
                                  0, 0), 0, zero_res});
    // Inverted band never matches; extreme wall coordinates.
    rows.insert(rows.size(), '{mk(ACT_APPEND, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h7fffffff, 32'h00010000, 32'hffff0000, 0, 0, 0, 0, 0),
                               1, zero_res});
    rows.insert(rows.size(), '{mk(ACT_APPEND, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0),
                               1, zero_res});
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h7fffffff, 32'h80000000), 0, zero_res});
    rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                  32'h80000000, 32'h80000000, 32'h7fffffff), 0, zero_res});
    // Unused action code gives all zero.
    rows.insert(rows.size(), '{mk(2'd3, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
                               1, zero_res});
    rows.insert(rows.size(), '{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    // Fill the table to capacity, refuse one more, query a full table.
    for (int i = 0; i < NWALL; i++) send_item(rand_wall(), 0, zero_res);
    send_item(rand_wall(), 1, full_res);
    send_item(rand_query(), 0, zero_res);
    send_item(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res);

    // Random scenes: a few walls, then queries, with some noise.
    n = 0;
    while (n < 420) begin
      if (n > 350) idle_phase = 1'b1;
      case ($urandom_range(0, 19))
        0: it = mk(ACT_CLEAR, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                   rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
        1: it = mk(2'd3, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                   rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
        2, 3, 4, 5, 6: it = (tb_walls < 12) ? rand_wall() : rand_query();
        default: it = rand_query();
      endcase
      send_item(it, 0, zero_res);
      n++;
    end
    in_ch.valid <= 1'b0;
    idle_phase = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    stim_done = 1'b1;
  end

  // Run end and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stim_done) begin
      $display("Covered %0d results, %0d clamp queries over a full wall table and random scenes.",
               results_seen, queries_sent);
      if (mismatch_count == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end else if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
